>>> rtl/core/nlpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpt_pkg
// Shared types and constants of the node liveness poll table.
// ----------------------------------------------------------------------------
package nlpt_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_PACKET = 1'b1;

  localparam logic [1:0] MSG_HELLO = 2'd0;
  localparam logic [1:0] MSG_DATA  = 2'd1;

  localparam logic [1:0] K_HELLO     = 2'd0;
  localparam logic [1:0] K_HELLO_ACK = 2'd1;
  localparam logic [1:0] K_DATA_ACK  = 2'd2;
  localparam logic [1:0] K_POLL      = 2'd3;

  localparam logic [2:0] REG_POLL_AGE     = 3'd0;
  localparam logic [2:0] REG_RESEND_LIMIT = 3'd1;
  localparam logic [2:0] REG_POLL_HOLDOFF = 3'd2;
  localparam logic [2:0] REG_HELLO_SECS   = 3'd3;
  localparam logic [2:0] REG_TICKS_PER_S  = 3'd4;

  typedef struct packed {
    logic        used;
    logic [15:0] age;
    logic [2:0]  resends;
    logic [7:0]  holdoff;
    logic [7:0]  addr_hi;
    logic [7:0]  addr_lo;
  } entry_t;

endpackage

>>> rtl/core/nlpt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlpt_cell
// One table entry of the rotating ring; takes its neighbour's entry on shift.
// ----------------------------------------------------------------------------
module nlpt_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  nlpt_pkg::entry_t d,
  output nlpt_pkg::entry_t q
);

  logic             used;
  nlpt_pkg::entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (shift) begin
      used <= d.used;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= d;
    end
  end

  always_comb begin
    q      = ent;
    q.used = used;
  end

endmodule

>>> rtl/core/node_liveness_poll_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_liveness_poll_table
// Sink node table: acks and polls senders, ages and evicts entries and broadcasts hello on ticks.
// ----------------------------------------------------------------------------
// channel  | handshake          | payload
// command  | start, busy        | cmd, length_ok, checksum_ok, msg_kind,
//          |                    | src_addr_hi, src_addr_lo
// result   | strobe (1 cycle)   | send_kind, dest_addr_hi, dest_addr_lo, last
// config   | cfg_we             | cfg_index, cfg_data
//
// Entries sit in a ring of cells that rotates one place a cycle during a pass;
// the controller edits the entry at the head. Update, test ticks: one pass.
// Poll tick: one pass and a drain step. Good hello/data packet: a search pass
// and a store pass. Other items need no pass. Results are registered; no stall is possible.
// Reset is synchronous; the table comes up empty.
// ----------------------------------------------------------------------------
module node_liveness_poll_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cmd,
  input  logic        length_ok,
  input  logic        checksum_ok,
  input  logic [1:0]  msg_kind,
  input  logic [7:0]  src_addr_hi,
  input  logic [7:0]  src_addr_lo,
  output logic        strobe,
  output logic [1:0]  send_kind,
  output logic [7:0]  dest_addr_hi,
  output logic [7:0]  dest_addr_lo,
  output logic        last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int N  = nlpt_pkg::TABLE_ENTRIES;
  localparam int IW = nlpt_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  typedef enum logic [4:0] {
    PH_HELLO  = 5'b00001,
    PH_UPDATE = 5'b00010,
    PH_TEST   = 5'b00100,
    PH_POLL   = 5'b01000,
    PH_WAIT   = 5'b10000
  } phase_t;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  typedef enum logic [2:0] {
    OP_AGE, OP_TEST, OP_POLL, OP_FIND, OP_STORE
  } op_t;

  logic [15:0] poll_age_limit;
  logic [2:0]  resend_limit;
  logic [7:0]  poll_holdoff;
  logic [5:0]  hello_secs;
  logic [7:0]  ticks_per_second;

  state_t      state;
  phase_t      phase;
  op_t         op;
  logic [IW-1:0] cnt;
  logic [7:0]  tick_count;
  logic [5:0]  second_count;
  logic        any_out;
  logic        found;
  logic        free_seen;
  logic [IW-1:0] hit_idx;
  logic [IW-1:0] free_idx;
  logic [7:0]  pkt_hi;
  logic [7:0]  pkt_lo;
  logic        pend_valid;
  logic [7:0]  pend_hi;
  logic [7:0]  pend_lo;

  nlpt_pkg::entry_t ring [N];
  nlpt_pkg::entry_t head;
  nlpt_pkg::entry_t fb;
  logic             shift;
  logic             timed;
  logic             poll_now;
  logic             addr_match;

  logic [7:0]  tc_inc;
  logic [7:0]  tc_sel;
  logic        sec_elapsed;
  logic [5:0]  sc_inc;
  logic        to_hello;
  logic [IW-1:0] tgt_idx;
  logic        tgt_ok;

  assign busy  = (state != S_IDLE);
  assign shift = (state == S_SCAN);
  assign head  = ring[N-1];

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == 0) begin : g_first
        nlpt_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(fb), .q(ring[g]));
      end else begin : g_rest
        nlpt_cell u_cell (.clk(clk), .rst(rst), .shift(shift), .d(ring[g-1]),
                          .q(ring[g]));
      end
    end
  endgenerate

  assign timed      = head.used && (head.age >= poll_age_limit);
  assign addr_match = (head.addr_hi == pkt_hi) && (head.addr_lo == pkt_lo);
  assign tgt_idx    = found ? hit_idx : free_idx;
  assign tgt_ok     = found || free_seen;

  always_comb begin
    fb       = head;
    poll_now = 1'b0;
    case (op)
      OP_AGE: begin
        if (head.used && head.age != 16'hFFFF) fb.age = head.age + 16'd1;
      end
      OP_POLL: begin
        if (timed) begin
          if (head.resends >= resend_limit) begin
            fb.used = 1'b0;
          end else if (head.holdoff == 8'd0) begin
            fb.resends = head.resends + 3'd1;
            fb.holdoff = poll_holdoff;
            poll_now   = 1'b1;
          end else begin
            fb.holdoff = head.holdoff - 8'd1;
          end
        end
      end
      OP_STORE: begin
        if (tgt_ok && cnt == tgt_idx) begin
          fb.used    = 1'b1;
          fb.addr_hi = pkt_hi;
          fb.addr_lo = pkt_lo;
          fb.age     = 16'd0;
          fb.resends = 3'd0;
          fb.holdoff = 8'd0;
        end
      end
      default: ;
    endcase
  end

  // second check
  assign tc_inc      = (tick_count == 8'hFF) ? tick_count : tick_count + 8'd1;
  assign tc_sel      = (state == S_IDLE) ? tc_inc : tick_count;
  assign sec_elapsed = (tc_sel >= ticks_per_second);
  assign sc_inc      = (second_count == 6'h3F) ? second_count : second_count + 6'd1;
  assign to_hello    = (sc_inc >= hello_secs);

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_age_limit   <= 16'd720;
      resend_limit     <= 3'd5;
      poll_holdoff     <= 8'd50;
      hello_secs       <= 6'd30;
      ticks_per_second <= 8'd10;
      state            <= S_IDLE;
      phase            <= PH_HELLO;
      tick_count       <= 8'd0;
      second_count     <= 6'd0;
      strobe           <= 1'b0;
      pend_valid       <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          nlpt_pkg::REG_POLL_AGE:     poll_age_limit   <= cfg_data;
          nlpt_pkg::REG_RESEND_LIMIT: resend_limit     <= cfg_data[2:0];
          nlpt_pkg::REG_POLL_HOLDOFF: poll_holdoff     <= cfg_data[7:0];
          nlpt_pkg::REG_HELLO_SECS:   hello_secs       <= cfg_data[5:0];
          nlpt_pkg::REG_TICKS_PER_S:  ticks_per_second <= cfg_data[7:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd == nlpt_pkg::CMD_TICK) begin
              tick_count <= (phase == PH_WAIT && sec_elapsed) ? 8'd0 : tc_inc;
              cnt        <= '0;
              unique case (phase)
                PH_HELLO: begin
                  strobe       <= 1'b1;
                  send_kind    <= nlpt_pkg::K_HELLO;
                  dest_addr_hi <= 8'd0;
                  dest_addr_lo <= 8'd0;
                  last         <= 1'b1;
                  phase        <= PH_UPDATE;
                end
                PH_UPDATE: begin
                  op    <= OP_AGE;
                  state <= S_SCAN;
                  phase <= PH_TEST;
                end
                PH_TEST: begin
                  op      <= OP_TEST;
                  any_out <= 1'b0;
                  state   <= S_SCAN;
                end
                PH_POLL: begin
                  op         <= OP_POLL;
                  pend_valid <= 1'b0;
                  state      <= S_SCAN;
                end
                PH_WAIT: begin
                  if (sec_elapsed) begin
                    if (to_hello) begin
                      second_count <= 6'd0;
                      phase        <= PH_HELLO;
                    end else begin
                      second_count <= sc_inc;
                      phase        <= PH_UPDATE;
                    end
                  end
                end
                default: ;
              endcase
            end else if (length_ok) begin
              if (!checksum_ok) begin
                strobe       <= 1'b1;
                send_kind    <= nlpt_pkg::K_POLL;
                dest_addr_hi <= src_addr_hi;
                dest_addr_lo <= src_addr_lo;
                last         <= 1'b1;
              end else if (msg_kind == nlpt_pkg::MSG_HELLO ||
                           msg_kind == nlpt_pkg::MSG_DATA) begin
                strobe       <= 1'b1;
                send_kind    <= (msg_kind == nlpt_pkg::MSG_HELLO) ?
                                nlpt_pkg::K_HELLO_ACK : nlpt_pkg::K_DATA_ACK;
                dest_addr_hi <= src_addr_hi;
                dest_addr_lo <= src_addr_lo;
                last         <= 1'b1;
                pkt_hi       <= src_addr_hi;
                pkt_lo       <= src_addr_lo;
                found        <= 1'b0;
                free_seen    <= 1'b0;
                op           <= OP_FIND;
                cnt          <= '0;
                state        <= S_SCAN;
              end
            end
          end
        end
        S_SCAN: begin
          cnt <= (cnt == LAST_IDX) ? '0 : cnt + 1'b1;
          case (op)
            OP_TEST: begin
              if (timed) any_out <= 1'b1;
            end
            OP_POLL: begin
              if (poll_now) begin
                if (pend_valid) begin
                  strobe       <= 1'b1;
                  send_kind    <= nlpt_pkg::K_POLL;
                  dest_addr_hi <= pend_hi;
                  dest_addr_lo <= pend_lo;
                  last         <= 1'b0;
                end
                pend_valid <= 1'b1;
                pend_hi    <= head.addr_hi;
                pend_lo    <= head.addr_lo;
              end
            end
            OP_FIND: begin
              if (!found) begin
                if (!head.used) begin
                  if (!free_seen) begin
                    free_seen <= 1'b1;
                    free_idx  <= cnt;
                  end
                end else if (addr_match) begin
                  found   <= 1'b1;
                  hit_idx <= cnt;
                end
              end
            end
            default: ;
          endcase
          if (cnt == LAST_IDX) begin
            case (op)
              OP_TEST: begin
                phase <= (any_out || timed) ? PH_POLL : PH_WAIT;
                state <= S_IDLE;
              end
              OP_POLL:  state <= S_DRAIN;
              OP_FIND:  op    <= OP_STORE;
              default:  state <= S_IDLE;
            endcase
          end
        end
        S_DRAIN: begin
          if (pend_valid) begin
            strobe       <= 1'b1;
            send_kind    <= nlpt_pkg::K_POLL;
            dest_addr_hi <= pend_hi;
            dest_addr_lo <= pend_lo;
            last         <= 1'b1;
          end
          pend_valid <= 1'b0;
          if (sec_elapsed) begin
            tick_count <= 8'd0;
            if (to_hello) begin
              second_count <= 6'd0;
              phase        <= PH_HELLO;
            end else begin
              second_count <= sc_inc;
              phase        <= PH_UPDATE;
            end
          end else begin
            phase <= PH_TEST;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result that is not the last of its transaction is followed by more work
  a_more_follows: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy)
    else $error("non-final result while idle");

  a_hello_tick: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd == nlpt_pkg::CMD_TICK && phase == PH_HELLO
    |=> strobe && send_kind == nlpt_pkg::K_HELLO && last)
    else $error("hello phase tick gave no broadcast");

  a_drain_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |=> state == S_IDLE && !pend_valid)
    else $error("drain did not return to idle");

  a_scan_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && cnt == LAST_IDX && op == OP_FIND |=> state == S_SCAN && cnt == '0)
    else $error("store pass did not follow search pass");

endmodule
